FILE: rtl/core/lru_key_value_cache_assert.svh
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define LKVC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lkvc: invariant violated");

// Antecedent implies consequent in the same cycle.
`define LKVC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc: same-cycle implication violated");

// Antecedent implies consequent in the next cycle.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc: next-cycle implication violated");

`endif

FILE: rtl/core/lkvc_pkg.sv
// Package: sizes, codes, command struct and encoders for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic ACTION_GET = 1'b0;
  localparam logic ACTION_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_MATCH  = 3'b010,
    ST_UPDATE = 3'b100
  } lkvc_state_e;

  typedef struct packed {
    logic load_req;  // latch the request on its transfer
    logic capture;   // register compare and search results
    logic commit;    // apply the state update and load the result
  } lkvc_cmd_t;

  // Encode a one-hot (or zero) vector into an index.
  function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (vec[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest set bit, zero if none.
  function automatic logic [IDX_W-1:0] lowest_set(input logic [ENTRIES-1:0] vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lkvc_req_if.sv
// Request channel: valid/ready handshake carrying action, key and value.
`default_nettype none

interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, output action, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input action, input lookup_key, input write_value,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lkvc_rsp_if.sv
// Response channel: valid/ready handshake carrying hit flag and value.
`default_nettype none

interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lkvc_datapath.sv
// Datapath: entry store, parallel key compare, recency ranks and result register.
`default_nettype none
`include "lru_key_value_cache_assert.svh"

module lkvc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lkvc_pkg::lkvc_cmd_t              cmd_i,
  input  logic                             req_action_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0] req_key_i,
  input  logic signed [lkvc_pkg::VAL_W-1:0] req_value_i,
  input  logic                             cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]       cfg_wdata_i,
  output logic                             found_o,
  output logic signed [lkvc_pkg::VAL_W-1:0] read_value_o
);
  import lkvc_pkg::*;

  // Latched request
  logic             action_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] wval_q;

  // Entry store
  logic [ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]   entry_key_q   [ENTRIES];
  logic [VAL_W-1:0]   entry_value_q [ENTRIES];
  logic [IDX_W-1:0]   rank_q        [ENTRIES];
  logic [CNT_W-1:0]   used_q;
  logic [CAP_W-1:0]   cap_q;

  // Registered lookup results
  logic [ENTRIES-1:0] hit_vec_q;
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [ENTRIES-1:0] victim_vec_q;
  logic [IDX_W-1:0]   victim_idx_q;
  logic               room_q;

  // Result register
  logic             found_q;
  logic [VAL_W-1:0] read_value_q;

  logic [ENTRIES-1:0] hit_vec_d;
  logic [ENTRIES-1:0] victim_vec_d;
  logic [IDX_W-1:0]   last_rank;
  logic [CMP_W-1:0]   eff_cap;
  logic               room_d;

  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] old_rank;
  logic             age_all;
  logic             do_change;
  logic             do_fill;

  // Clamp the configured capacity to 1 .. ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  // Compare the key against every entry; the LRU entry holds rank used-1
  assign last_rank = IDX_W'(used_q - CNT_W'(1));
  assign room_d    = CMP_W'(used_q) < eff_cap;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec_d[i]    = valid_q[i] && (entry_key_q[i] == key_q);
      victim_vec_d[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
  end

  // Hold the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      action_q <= req_action_i;
      key_q    <= req_key_i;
      wval_q   <= req_value_i;
    end
  end

  // Register compare and search results
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_vec_q    <= hit_vec_d;
      hit_q        <= |hit_vec_d;
      hit_idx_q    <= onehot_to_idx(hit_vec_d);
      free_idx_q   <= lowest_set(~valid_q);
      victim_vec_q <= victim_vec_d;
      victim_idx_q <= onehot_to_idx(victim_vec_d);
      room_q       <= room_d;
    end
  end

  // Pick the target slot and the rank boundary for aging
  always_comb begin
    do_change = hit_q || (action_q == ACTION_PUT);
    do_fill   = (action_q == ACTION_PUT) && !hit_q && room_q;
    age_all   = 1'b0;
    if (hit_q) begin
      slot     = hit_idx_q;
      old_rank = rank_q[hit_idx_q];
    end else if (room_q) begin
      slot     = free_idx_q;
      old_rank = '0;
      age_all  = 1'b1;
    end else begin
      slot     = victim_idx_q;
      old_rank = last_rank;
    end
  end

  // Update valid bits, ranks, fill count and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      cap_q   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && do_change) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (age_all || rank_q[i] < old_rank)) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end
      end
      if (cmd_i.commit && do_fill) begin
        valid_q[slot] <= 1'b1;
        used_q        <= used_q + CNT_W'(1);
      end
    end
  end

  // Write key and value on a put
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (action_q == ACTION_PUT)) begin
      entry_key_q[slot]   <= key_q;
      entry_value_q[slot] <= wval_q;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_q <= hit_q;
      if (action_q == ACTION_PUT) begin
        read_value_q <= wval_q;
      end else if (hit_q) begin
        read_value_q <= entry_value_q[hit_idx_q];
      end else begin
        read_value_q <= MISS_VALUE;
      end
    end
  end

  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  `LKVC_ASSERT_ALWAYS(a_used_matches_valid, clk_i, rst_ni, $countones(valid_q) == int'(used_q))
  `LKVC_ASSERT_IMPLIES(a_hit_unique, clk_i, rst_ni, cmd_i.commit, $onehot0(hit_vec_q))
  `LKVC_ASSERT_IMPLIES(a_victim_exists, clk_i, rst_ni,
    cmd_i.commit && (action_q == ACTION_PUT) && !hit_q && !room_q, $onehot(victim_vec_q))

endmodule

`default_nettype wire

FILE: rtl/core/lkvc_ctrl.sv
// Controller: request sequencing state machine and result valid flag.
`default_nettype none
`include "lru_key_value_cache_assert.svh"

module lkvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                rsp_ready_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  output lkvc_pkg::lkvc_cmd_t cmd_o
);
  import lkvc_pkg::*;

  lkvc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Decode commands from the current state
  always_comb begin
    cmd_o.load_req = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.capture  = (state_q == ST_MATCH);
    cmd_o.commit   = (state_q == ST_UPDATE) && (!out_valid_q || rsp_ready_i);
  end

  // Advance through accept, compare and commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Set on commit, drop once the result transfer completes
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  `LKVC_ASSERT_NEXT(a_accept_to_match, clk_i, rst_ni, req_valid_i && req_ready_o,
    state_q == ST_MATCH)
  `LKVC_ASSERT_NEXT(a_match_to_update, clk_i, rst_ni, state_q == ST_MATCH,
    state_q == ST_UPDATE)
  `LKVC_ASSERT_NEXT(a_commit_sets_valid, clk_i, rst_ni, cmd_o.commit,
    out_valid_q && state_q == ST_IDLE)
  `LKVC_ASSERT_IMPLIES(a_busy_not_ready, clk_i, rst_ni, state_q != ST_IDLE, !req_ready_o)

endmodule

`default_nettype wire

FILE: rtl/core/lru_key_value_cache.sv
// Top level: LRU key-value cache built from controller and datapath.
//
// Fully associative store of lkvc_pkg::ENTRIES key/value pairs with least-recently-used
// replacement. Each request passes the states idle (its transfer), match, which
// compares the key against every entry in parallel and locates the free and LRU entries,
// and update, whose commit updates ranks, writes the entry and loads the result
// register; a new request is taken the cycle after commit, so a request is not accepted
// before the previous one commits. The result register lets the next request in while a
// result still waits; a commit stalls only while the previous result is not yet taken.
// The capacity register (reset 16) is written with cfg_we_i; 0 acts as 1, values above
// the entry count saturate, and write it only while no request is in flight.
`default_nettype none

module lru_key_value_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lkvc_req_if.sink                   req_i,
  lkvc_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  lkvc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_action_i (req_i.action),
    .req_key_i    (req_i.lookup_key),
    .req_value_i  (req_i.write_value),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .found_o      (rsp_o.found),
    .read_value_o (rsp_o.read_value)
  );

endmodule

`default_nettype wire

FILE: test/lru_key_value_cache_checker.sv
// Checker for the LRU key-value cache: mirrors the store, predicts every reply and compares.
`timescale 1ns / 1ps

module lru_key_value_cache_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lkvc_req_if                        req_i,
  lkvc_rsp_if                        rsp_i,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         replies_o,
  output int                         hits_o,
  output int                         evictions_o
);
  import lkvc_pkg::*;

  // Keep the log short when the block is badly off.
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } cache_reply_t;

  // Mirror of the store
  logic             slot_valid [ENTRIES];
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];
  int unsigned      slot_rank  [ENTRIES];
  int               slots_used;
  logic [CAP_W-1:0] capacity;

  cache_reply_t     expected_replies [$];
  cache_reply_t     oldest_reply;

  task automatic report_mismatch(input string msg);
    errors_o++;
    if (errors_o <= PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Make a slot the most recent; valid slots more recent than old_rank age by one.
  function automatic void touch_slot(input int slot, input int unsigned old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != slot && slot_valid[i] && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[slot] = 0;
  endfunction

  // Apply one get or put to the mirror and return the reply it should produce.
  function automatic cache_reply_t access_cache(input logic act, input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] wval);
    cache_reply_t reply;
    int           hit;
    int           slot;
    int           limit;
    int unsigned  worst;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
    end
    reply.found = (hit >= 0);

    // Lookup: hit returns the stored value, miss returns the all-ones marker
    if (act == ACTION_GET) begin
      if (hit >= 0) begin
        reply.value = slot_value[hit];
        touch_slot(hit, slot_rank[hit]);
        hits_o++;
      end else begin
        reply.value = MISS_VALUE;
      end
      return reply;
    end

    // Insert or update: the reply echoes the written value
    reply.value = wval;
    if (hit >= 0) begin
      slot_value[hit] = wval;
      touch_slot(hit, slot_rank[hit]);
      hits_o++;
      return reply;
    end

    // Clamp the capacity: zero acts as one, above the entry count saturates
    limit = (capacity == 0) ? 1 : ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
    if (slots_used < limit) begin
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !slot_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        touch_slot(slot, 32'hFFFF_FFFF);
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = wval;
        slots_used++;
      end
    end else begin
      // Evict the least recently used slot
      slot  = -1;
      worst = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && (slot < 0 || slot_rank[i] > worst)) begin
          slot  = i;
          worst = slot_rank[i];
        end
      end
      if (slot >= 0) begin
        slot_key[slot]   = key;
        slot_value[slot] = wval;
        touch_slot(slot, worst);
        evictions_o++;
      end
    end
    return reply;
  endfunction

  // Watch the channels: compare replies against the oldest prediction, predict new requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_rank[i]  = 0;
      end
      slots_used  = 0;
      capacity    = CAP_RESET;
      errors_o    = 0;
      replies_o   = 0;
      hits_o      = 0;
      evictions_o = 0;
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;

      if (rsp_i.valid && rsp_i.ready) begin
        replies_o++;
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply with nothing outstanding: found=%b value=%h",
                                    rsp_i.found, rsp_i.read_value));
        end else begin
          oldest_reply = expected_replies.pop_front();
          if (rsp_i.found !== oldest_reply.found)
            report_mismatch($sformatf("reply %0d found: got %b, want %b", replies_o,
                                      rsp_i.found, oldest_reply.found));
          if (rsp_i.read_value !== oldest_reply.value)
            report_mismatch($sformatf("reply %0d read_value: got %h, want %h", replies_o,
                                      rsp_i.read_value, oldest_reply.value));
        end
      end

      if (req_i.valid && req_i.ready)
        expected_replies.push_back(access_cache(req_i.action, req_i.lookup_key,
                                                req_i.write_value));

      pending_o <= expected_replies.size();
    end
  end

endmodule

FILE: test/lru_key_value_cache_tb.sv
// Testbench top for the LRU key-value cache: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 108;
  localparam int LONG_HOLD   = 60;
  localparam int QUIET_LIMIT = 2000;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SNK_STALL,
    FLOW_BOTH
  } flow_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int errors;
  int outstanding;
  int replies;
  int hits;
  int evictions;

  int src_idle_pct;
  int snk_stall_pct;
  logic hold_token;
  logic hold_seen;
  int hold_left;
  int quiet_cycles = 0;
  int requests_sent = 0;
  int cfg_writes = 0;
  int phase_caps [PHASES] = '{16, 1, 4, 31, 0, 8, 2, 16, 12, 3, 31, 5};

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_key_value_cache u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lru_key_value_cache_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (outstanding),
    .replies_o   (replies),
    .hits_o      (hits),
    .evictions_o (evictions)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Drive reply ready: long hold-off on request, otherwise random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= LONG_HOLD - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d replies outstanding",
               QUIET_LIMIT, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_req(input logic act, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] wval);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.lookup_key  <= key;
    req_if.write_value <= wval;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop offering and wait until every predicted reply has come back
  task automatic wait_for_replies();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Write the capacity register with the block idle
  task automatic set_capacity(input int cap);
    wait_for_replies();
    repeat (3) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(cap);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_flow(input flow_mode_e mode);
    src_idle_pct  =  (mode == FLOW_SRC_IDLE)  ? 73 : ((mode == FLOW_BOTH) ? 16 : 0);
    snk_stall_pct <= (mode == FLOW_SNK_STALL) ? 73 : ((mode == FLOW_BOTH) ? 16 : 0);
  endtask

  // Stimulus
  initial begin
    logic [KEY_W-1:0] key_pool [32];
    logic [KEY_W-1:0] key;
    int               pool_size;
    int               eff_cap;

    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACTION_GET;
    req_if.lookup_key  <= '0;
    req_if.write_value <= '0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    hold_token         <= 1'b0;
    src_idle_pct       = 0;
    snk_stall_pct      <= 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lookup on an empty store, extreme keys and values, hits and an update
    send_req(ACTION_GET, 32'h0000_0000, 32'h0000_0005);
    send_req(ACTION_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_req(ACTION_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(ACTION_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(ACTION_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(ACTION_GET, 32'h8000_0000, 32'h0000_0000);
    send_req(ACTION_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_req(ACTION_GET, 32'h0000_0000, 32'h8000_0000);
    send_req(ACTION_GET, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_req(ACTION_PUT, 32'h0000_0000, 32'h1234_5678);
    send_req(ACTION_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(ACTION_GET, 32'h0000_0001, 32'hAAAA_AAAA);

    // Capacity lowered below the entries in use: misses evict, count stays
    set_capacity(2);
    send_req(ACTION_PUT, 32'h0000_0005, 32'h0000_0055);
    send_req(ACTION_GET, 32'h8000_0000, 32'h5555_5555);
    send_req(ACTION_PUT, 32'h0000_0006, 32'h0000_0066);
    send_req(ACTION_GET, 32'h0000_0005, 32'h0000_0000);

    // Capacity zero acts as one
    set_capacity(0);
    send_req(ACTION_PUT, 32'h0000_0007, 32'h0000_0077);
    send_req(ACTION_GET, 32'h0000_0007, 32'h0000_0000);
    send_req(ACTION_GET, 32'h0000_0006, 32'h0000_0000);

    // Capacity above the entry count saturates
    set_capacity(31);
    send_req(ACTION_PUT, 32'h0000_0008, 32'h0000_0088);
    send_req(ACTION_PUT, 32'h0000_0009, 32'h0000_0099);
    send_req(ACTION_GET, 32'h0000_0008, 32'h0000_0000);

    // Random phases: keys mostly from a small pool so hits, fills and evictions all occur
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      set_flow(flow_mode_e'(p % 4));
      eff_cap   = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > ENTRIES) ? ENTRIES : phase_caps[p]);
      pool_size = eff_cap + $urandom_range(1, 8);
      if (pool_size > 32) pool_size = 32;
      for (int k = 0; k < 32; k++) key_pool[k] = $urandom;

      // Hold the reply side off while requests keep coming, so the block backs up
      if (p == 0 || p == 7) hold_token <= ~hold_token;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
        else key = $urandom;
        send_req($urandom_range(0, 1) ? ACTION_PUT : ACTION_GET, key, $urandom);
        if ($urandom_range(0, 63) == 0) wait_for_replies();
      end
    end

    // Drain and give the verdict
    wait_for_replies();
    repeat (6) @(posedge clk_i);
    $display("Covered %0d requests over %0d capacity settings, zero and saturating ones included;",
             requests_sent, cfg_writes);
    $display("checked %0d replies with %0d hits and %0d evictions.", replies, hits, evictions);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
